// ===== rtl/core/mcsw_pkg.sv =====
// ----------------------------------------------------------------------------
// mcsw_pkg
// Shared types and constants of the multi-channel soft watchdog: opcodes,
// result codes, register indexes, the slot entry layout, the tick outcome
// and the controller state type.
// ----------------------------------------------------------------------------
package mcsw_pkg;

   // Field widths fixed by the interface.
   localparam int KEY_W      = 32;
   localparam int TIME_W     = 24;
   localparam int STEP_W     = 16;
   localparam int OP_W       = 3;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;

   // Opcodes of an input beat.
   localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
   localparam logic [OP_W-1:0] OP_ATTACH = 3'd1;
   localparam logic [OP_W-1:0] OP_DETACH = 3'd2;
   localparam logic [OP_W-1:0] OP_FEED   = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_DONE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WARN    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_STEP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REBOOT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HW_KICK   = 2'd2;

   localparam logic [STEP_W-1:0] TICK_STEP_RESET = 16'd1000;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   // One word of the slot table.
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] remaining;
      logic [TIME_W-1:0] timeout;
   } slot_entry_type;

   // Outcome of a tick on one slot.
   typedef struct packed {
      logic              armed;
      logic              report;
      logic              expired;
      logic [TIME_W-1:0] rem_new;
   } tick_eval_type;

endpackage

// ===== rtl/core/mcsw_tick_eval.sv =====
// ----------------------------------------------------------------------------
// mcsw_tick_eval
// Applies one tick to a slot entry: saturating countdown of the remaining
// time and the decision whether the slot reports a warning or an expiry.
// ----------------------------------------------------------------------------
module mcsw_tick_eval (
   input  logic                           slot_valid,
   input  mcsw_pkg::slot_entry_type       entry,
   input  logic [mcsw_pkg::STEP_W-1:0]    step,
   output mcsw_pkg::tick_eval_type        result
);

   logic [mcsw_pkg::TIME_W-1:0] step_ext;
   logic [mcsw_pkg::TIME_W-1:0] rem_new;
   logic                        warn;

   assign step_ext = {{(mcsw_pkg::TIME_W - mcsw_pkg::STEP_W){1'b0}}, step};

   // Count down, saturating at zero.
   assign rem_new = (entry.remaining > step_ext) ? entry.remaining - step_ext
                                                 : '0;

   // Warning when twice the remaining time drops below the timeout.
   assign warn = {rem_new, 1'b0} < {1'b0, entry.timeout};

   always_comb begin
      result.armed   = slot_valid && (entry.timeout != '0);
      result.expired = (rem_new == '0);
      result.rem_new = rem_new;
      result.report  = result.armed && (result.expired || warn);
   end

endmodule

// ===== rtl/core/multi_channel_soft_watchdog.sv =====
// ----------------------------------------------------------------------------
// multi_channel_soft_watchdog
// Keyed table of software watchdog channels with tick, attach, detach, feed
// and query operations.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (req_*) carry an opcode, a key and a timeout. A tick counts
//   down every armed channel and reports each channel in warning or expiry,
//   in slot order, followed by a final beat with last set that carries the
//   hardware kick. Attach, detach, feed and query return one beat with last.
//   Opcodes above query are dropped without a result.
//   Each accepted beat walks the slot table once through a memory with one
//   write port and one registered read port, one slot per cycle unless a
//   report waits for the output register, then finishes in ST_FINISH. A
//   new beat is taken only after the block is back in idle.
//   Results pass through an output register. When it is full and
//   rsp_ready is low the walk holds on the reporting slot, so nothing is lost.
//   Configuration writes (csr_*) are always taken and must only be issued
//   while the block is idle.
//   Reset empties the table at once (valid bits in flip-flops) and loads the
//   register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_channel_soft_watchdog #(
   parameter int SLOTS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mcsw_pkg::OP_W-1:0]           req_opcode,
   input  logic [mcsw_pkg::KEY_W-1:0]          req_key,
   input  logic [mcsw_pkg::TIME_W-1:0]         req_timeout,
   // Result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mcsw_pkg::KIND_W-1:0]         rsp_kind,
   output logic [mcsw_pkg::KEY_W-1:0]          rsp_channel_key,
   output logic [mcsw_pkg::TIME_W-1:0]         rsp_remaining,
   output logic                                rsp_found,
   output logic [mcsw_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                rsp_hw_kick,
   output logic                                rsp_reboot_request,
   output logic                                rsp_last,
   // Configuration channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mcsw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mcsw_pkg::STEP_W-1:0]         csr_wdata
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   // Controller state and latched request.
   mcsw_pkg::state_type                 state_ff, state_in;
   logic [mcsw_pkg::OP_W-1:0]           op_ff;
   logic [mcsw_pkg::KEY_W-1:0]          key_ff;
   logic [mcsw_pkg::TIME_W-1:0]         tmo_ff;
   logic [IDX_W-1:0]                    idx_ff;

   // Lookup results gathered during the walk.
   logic                                hit_ff;
   logic [IDX_W-1:0]                    hit_idx_ff;
   logic [mcsw_pkg::TIME_W-1:0]         hit_rem_ff;
   logic                                free_ff;
   logic [IDX_W-1:0]                    free_idx_ff;

   // Configuration registers.
   logic [mcsw_pkg::STEP_W-1:0]         step_ff;
   logic                                reboot_ff;
   logic                                kick_ff;

   // Slot table: valid bits in flip-flops, payload in memory.
   logic [SLOTS-1:0]                    valid_ff;
   mcsw_pkg::slot_entry_type            mem [SLOTS];
   mcsw_pkg::slot_entry_type            rd_data_ff;

   // Output register.
   logic                                rsp_valid_ff;
   logic [mcsw_pkg::KIND_W-1:0]         kind_ff;
   logic [mcsw_pkg::KEY_W-1:0]          out_key_ff;
   logic [mcsw_pkg::TIME_W-1:0]         out_rem_ff;
   logic                                found_ff;
   logic [mcsw_pkg::STATUS_W-1:0]       status_ff;
   logic                                hw_kick_ff;
   logic                                reboot_req_ff;
   logic                                last_ff;

   // Control produced by the output logic.
   logic                                accept;
   logic                                out_free;
   logic                                advance;
   logic                                last_slot;
   logic                                rd_en;
   logic [IDX_W-1:0]                    rd_addr;
   logic                                wr_en;
   logic [IDX_W-1:0]                    wr_addr;
   mcsw_pkg::slot_entry_type            wr_data;
   logic                                valid_set;
   logic                                valid_clr;
   logic [IDX_W-1:0]                    valid_idx;
   logic                                emit;
   logic [mcsw_pkg::KIND_W-1:0]         e_kind;
   logic [mcsw_pkg::KEY_W-1:0]          e_key;
   logic [mcsw_pkg::TIME_W-1:0]         e_rem;
   logic                                e_found;
   logic [mcsw_pkg::STATUS_W-1:0]       e_status;
   logic                                e_kick;
   logic                                e_reboot;

   logic [IDX_W-1:0]                    next_idx;
   logic                                cur_valid;
   logic                                key_match;
   mcsw_pkg::tick_eval_type             tick;

   assign next_idx  = idx_ff + IDX_W'(1);
   assign last_slot = (idx_ff == LAST_IDX);
   assign cur_valid = valid_ff[idx_ff];
   assign key_match = cur_valid && (rd_data_ff.key == key_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Tick countdown and report decision for the slot being walked.
   mcsw_tick_eval u_tick_eval (
      .slot_valid (cur_valid),
      .entry      (rd_data_ff),
      .step       (step_ff),
      .result     (tick)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mcsw_pkg::ST_IDLE: begin
            if (accept && (req_opcode <= mcsw_pkg::OP_QUERY)) begin
               state_in = mcsw_pkg::ST_WALK;
            end
         end
         mcsw_pkg::ST_WALK: begin
            if (advance && last_slot) begin
               state_in = mcsw_pkg::ST_FINISH;
            end
         end
         mcsw_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = mcsw_pkg::ST_IDLE;
            end
         end
         default: state_in = mcsw_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the controller: memory port, valid bits and result beat.
   always_comb begin
      req_ready = 1'b0;
      advance   = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = rd_data_ff;
      valid_set = 1'b0;
      valid_clr = 1'b0;
      valid_idx = hit_idx_ff;
      emit      = 1'b0;
      e_kind    = mcsw_pkg::KIND_DONE;
      e_key     = key_ff;
      e_rem     = '0;
      e_found   = 1'b0;
      e_status  = mcsw_pkg::STATUS_OK;
      e_kick    = 1'b0;
      e_reboot  = 1'b0;
      unique case (state_ff)
         mcsw_pkg::ST_IDLE: begin
            // Slot 0 is read ahead so the walk starts right after acceptance.
            req_ready = 1'b1;
            rd_en     = 1'b1;
         end
         mcsw_pkg::ST_WALK: begin
            if (op_ff == mcsw_pkg::OP_TICK) begin
               // A slot with a report waits until the output register is free.
               advance  = !tick.report || out_free;
               emit     = tick.report && out_free;
               wr_en    = advance && tick.armed;
               wr_data.remaining = tick.rem_new;
               e_kind   = tick.expired ? mcsw_pkg::KIND_EXPIRED : mcsw_pkg::KIND_WARN;
               e_key    = rd_data_ff.key;
               e_rem    = tick.rem_new;
               e_found  = 1'b1;
               e_reboot = tick.expired && reboot_ff;
            end else begin
               advance = 1'b1;
            end
            if (advance && !last_slot) begin
               rd_en   = 1'b1;
               rd_addr = next_idx;
            end
         end
         mcsw_pkg::ST_FINISH: begin
            emit = out_free;
            if (op_ff == mcsw_pkg::OP_TICK) begin
               e_key  = '0;
               e_kick = kick_ff;
            end else if (op_ff == mcsw_pkg::OP_ATTACH) begin
               if (hit_ff) begin
                  e_found = 1'b1;
                  e_rem   = hit_rem_ff;
               end else if (free_ff) begin
                  // New channel, disarmed, in the lowest free slot.
                  wr_en     = out_free;
                  wr_addr   = free_idx_ff;
                  wr_data   = '{key: key_ff, remaining: '0, timeout: '0};
                  valid_set = out_free;
                  valid_idx = free_idx_ff;
               end else begin
                  e_status = mcsw_pkg::STATUS_FULL;
               end
            end else if (!hit_ff) begin
               e_status = mcsw_pkg::STATUS_NOT_FOUND;
            end else begin
               e_found = 1'b1;
               unique case (op_ff)
                  mcsw_pkg::OP_DETACH: begin
                     valid_clr = out_free;
                  end
                  mcsw_pkg::OP_FEED: begin
                     wr_en   = out_free;
                     wr_addr = hit_idx_ff;
                     wr_data = '{key: key_ff, remaining: tmo_ff, timeout: tmo_ff};
                     e_rem   = tmo_ff;
                  end
                  default: begin
                     e_rem = hit_rem_ff;
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // Controller registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcsw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Request latch, walk index and lookup results.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_opcode;
         key_ff  <= req_key;
         tmo_ff  <= req_timeout;
         idx_ff  <= '0;
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if ((state_ff == mcsw_pkg::ST_WALK) && advance) begin
         if (!last_slot) begin
            idx_ff <= next_idx;
         end
         if (key_match && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= idx_ff;
            hit_rem_ff <= rd_data_ff.remaining;
         end
         if (!cur_valid && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= idx_ff;
         end
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= mcsw_pkg::TICK_STEP_RESET;
         reboot_ff <= 1'b0;
         kick_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mcsw_pkg::CSR_TICK_STEP: step_ff   <= csr_wdata;
            mcsw_pkg::CSR_REBOOT:    reboot_ff <= csr_wdata[0];
            mcsw_pkg::CSR_HW_KICK:   kick_ff   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Slot valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (valid_set) begin
         valid_ff[valid_idx] <= 1'b1;
      end else if (valid_clr) begin
         valid_ff[valid_idx] <= 1'b0;
      end
   end

   // Slot memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff       <= e_kind;
         out_key_ff    <= e_key;
         out_rem_ff    <= e_rem;
         found_ff      <= e_found;
         status_ff     <= e_status;
         hw_kick_ff    <= e_kick;
         reboot_req_ff <= e_reboot;
         last_ff       <= (state_ff == mcsw_pkg::ST_FINISH);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_channel_key    = out_key_ff;
   assign rsp_remaining      = out_rem_ff;
   assign rsp_found          = found_ff;
   assign rsp_status         = status_ff;
   assign rsp_hw_kick        = hw_kick_ff;
   assign rsp_reboot_request = reboot_req_ff;
   assign rsp_last           = last_ff;

endmodule
